// ===== rtl/core/ntew_pkg.sv =====
// shared types and constants for the number to english words block
package ntew_pkg;

   localparam int ValueWidth = 40;
   localparam int WordWidth  = 5;
   localparam int DigitCount = 12;
   localparam int BcdWidth   = 4 * DigitCount;
   localparam int CountWidth = $clog2(ValueWidth);

   localparam logic [ValueWidth-1:0] MaxValue = 40'd999999999999;

   localparam logic [WordWidth-1:0] TokZero      = 5'd0;
   localparam logic [WordWidth-1:0] TokTeenBase  = 5'd10;
   localparam logic [WordWidth-1:0] TokTensBase  = 5'd18;
   localparam logic [WordWidth-1:0] TokHundred   = 5'd28;
   localparam logic [WordWidth-1:0] TokScaleBase = 5'd28;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      PH_HUND_DIGIT,
      PH_HUND_WORD,
      PH_TENS,
      PH_ONES,
      PH_SCALE
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      shift;
      logic      walk_step;
      logic      flush;
      logic [1:0] group;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic value_err;
      logic value_zero;
      logic tok_valid;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/ntew_ctrl.sv =====
// controller: sequences binary to decimal conversion and the word walk
module ntew_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ntew_pkg::status_type status,
   output ntew_pkg::cmd_type    cmd
);
   import ntew_pkg::*;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [1:0]            group_ff, group_in;
   phase_type             phase_ff, phase_in;
   logic                  step_ok;
   logic                  walk_end;

   // a new token may only displace the pending one if the output can take it
   assign step_ok  = !(status.tok_valid && status.pend_valid && !status.out_free);
   assign walk_end = (group_ff == 2'd0) && (phase_ff == PH_SCALE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.value_err || status.value_zero) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            if (cnt_ff == CountWidth'(ValueWidth - 1)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (step_ok && walk_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.group     = group_ff;
      cmd.phase     = phase_ff;
      cnt_in        = cnt_ff;
      group_in      = group_ff;
      phase_in      = phase_ff;
      req_stall     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            cnt_in   = '0;
            group_in = 2'd3;
            phase_in = PH_HUND_DIGIT;
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
         end
         ST_WALK: begin
            cmd.walk_step = step_ok;
            if (step_ok) begin
               unique case (phase_ff)
                  PH_HUND_DIGIT: phase_in = PH_HUND_WORD;
                  PH_HUND_WORD:  phase_in = PH_TENS;
                  PH_TENS:       phase_in = PH_ONES;
                  PH_ONES:       phase_in = PH_SCALE;
                  PH_SCALE: begin
                     phase_in = PH_HUND_DIGIT;
                     group_in = group_ff - 1'b1;
                  end
                  default:       phase_in = PH_HUND_DIGIT;
               endcase
            end
         end
         ST_FLUSH: begin
            cmd.flush = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         group_ff <= 2'd3;
         phase_ff <= PH_HUND_DIGIT;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         group_ff <= group_in;
         phase_ff <= phase_in;
      end
   end

`ifndef SYNTHESIS
   // nothing may be left pending between requests
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !status.pend_valid)
      else $error("pending token left while idle");

   // a displaced pending token must have room at the output
   a_step_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step && status.tok_valid && status.pend_valid |-> status.out_free)
      else $error("pending token dropped during walk");

   // the final token must exist when flushed
   a_flush_has_token: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> status.pend_valid && status.out_free)
      else $error("flush without pending token");

   // conversion always runs straight into the walk
   a_conv_to_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV && cnt_ff == CountWidth'(ValueWidth - 1) |=> state_ff == ST_WALK)
      else $error("conversion did not end in walk");
`endif

endmodule

// ===== rtl/core/ntew_dp.sv =====
// datapath: double dabble conversion, token selection, pending and output registers
module ntew_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ntew_pkg::ValueWidth-1:0]     req_value,
   input  ntew_pkg::cmd_type                   cmd,
   output ntew_pkg::status_type                status,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [ntew_pkg::WordWidth-1:0]      rsp_word,
   output logic                                rsp_hyphen_join,
   output logic                                rsp_range_error,
   output logic                                rsp_last_word
);
   import ntew_pkg::*;

   logic [ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [BcdWidth-1:0]   bcd_adj;

   logic                 pend_valid_ff, pend_valid_in;
   logic [WordWidth-1:0] pend_word_ff, pend_word_in;
   logic                 pend_hyph_ff, pend_hyph_in;
   logic                 pend_err_ff, pend_err_in;

   logic                 out_valid_ff, out_valid_in;
   logic [WordWidth-1:0] out_word_ff, out_word_in;
   logic                 out_hyph_ff, out_hyph_in;
   logic                 out_err_ff, out_err_in;
   logic                 out_last_ff, out_last_in;

   logic [11:0]          grp;
   logic [3:0]           dig_h, dig_t, dig_o;
   logic                 tok_valid;
   logic [WordWidth-1:0] tok_word;
   logic                 tok_hyph;
   logic                 value_err, value_zero, out_free, push;

   assign value_err  = (req_value > MaxValue);
   assign value_zero = (req_value == '0);
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.group)
         2'd0:    grp = bcd_ff[11:0];
         2'd1:    grp = bcd_ff[23:12];
         2'd2:    grp = bcd_ff[35:24];
         default: grp = bcd_ff[47:36];
      endcase
   end

   assign dig_h = grp[11:8];
   assign dig_t = grp[7:4];
   assign dig_o = grp[3:0];

   always_comb begin
      tok_valid = 1'b0;
      tok_word  = TokZero;
      tok_hyph  = 1'b0;
      case (cmd.phase)
         PH_HUND_DIGIT: begin
            tok_valid = (dig_h != 4'd0);
            tok_word  = {1'b0, dig_h};
         end
         PH_HUND_WORD: begin
            tok_valid = (dig_h != 4'd0);
            tok_word  = TokHundred;
         end
         PH_TENS: begin
            if (dig_t >= 4'd2) begin
               tok_valid = 1'b1;
               tok_word  = TokTensBase + {1'b0, dig_t};
            end else if (dig_t == 4'd1) begin
               tok_valid = 1'b1;
               tok_word  = TokTeenBase + {1'b0, dig_o};
            end else begin
               tok_valid = (dig_o != 4'd0);
               tok_word  = {1'b0, dig_o};
            end
         end
         PH_ONES: begin
            tok_valid = (dig_t >= 4'd2) && (dig_o != 4'd0);
            tok_word  = {1'b0, dig_o};
            tok_hyph  = 1'b1;
         end
         PH_SCALE: begin
            tok_valid = (grp != 12'd0) && (cmd.group != 2'd0);
            tok_word  = TokScaleBase + {3'b000, cmd.group};
         end
         default: begin
            tok_valid = 1'b0;
         end
      endcase
   end

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < DigitCount; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
      end else if (cmd.shift) begin
         bin_in = {bin_ff[ValueWidth-2:0], 1'b0};
         bcd_in = {bcd_adj[BcdWidth-2:0], bin_ff[ValueWidth-1]};
      end
   end

   // the pending token goes out once a later one proves it is not the last, or on flush as the last word
   assign push = (cmd.walk_step && tok_valid && pend_valid_ff) || cmd.flush;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      pend_hyph_in  = pend_hyph_ff;
      pend_err_in   = pend_err_ff;
      if (cmd.load) begin
         pend_valid_in = value_err || value_zero;
         pend_word_in  = TokZero;
         pend_hyph_in  = 1'b0;
         pend_err_in   = value_err;
      end else if (cmd.walk_step && tok_valid) begin
         pend_valid_in = 1'b1;
         pend_word_in  = tok_word;
         pend_hyph_in  = tok_hyph;
         pend_err_in   = 1'b0;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      out_hyph_in  = out_hyph_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_word_in  = pend_word_ff;
         out_hyph_in  = pend_hyph_ff;
         out_err_in   = pend_err_ff;
         out_last_in  = cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      pend_word_ff <= pend_word_in;
      pend_hyph_ff <= pend_hyph_in;
      pend_err_ff  <= pend_err_in;
      out_word_ff  <= out_word_in;
      out_hyph_ff  <= out_hyph_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   assign status.value_err  = value_err;
   assign status.value_zero = value_zero;
   assign status.tok_valid  = tok_valid;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_word        = out_word_ff;
   assign rsp_hyphen_join = out_hyph_ff;
   assign rsp_range_error = out_err_ff;
   assign rsp_last_word   = out_last_ff;

endmodule

// ===== rtl/core/number_to_english_words.sv =====
// flow: a nonzero request in range is loaded, converted by 40 double-dabble shifts, then
// walked in 20 walk steps over four digit groups and flushed; a zero or out of range
// request goes from the load straight to the flush; each word passes through the pending
// and output registers, and the output register holds its word while rsp_stall is high;
// req_stall is high until the block is idle again, so a new request is taken only when idle
// reset: synchronous active high, returns to idle with no pending or output word
module number_to_english_words (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ntew_pkg::ValueWidth-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ntew_pkg::WordWidth-1:0]      rsp_word,
   output logic                                rsp_hyphen_join,
   output logic                                rsp_range_error,
   output logic                                rsp_last_word
);
   import ntew_pkg::*;

   cmd_type    cmd;
   status_type status;

   ntew_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ntew_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_word        (rsp_word),
      .rsp_hyphen_join (rsp_hyphen_join),
      .rsp_range_error (rsp_range_error),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
